// ===== rtl/q2k_pkg.sv =====
// shared types, constants and float helpers for the q2k row dot product
package q2k_pkg;

  localparam int unsigned SUPER_BLOCK = 256;
  localparam int unsigned LANES = 16;
  localparam int unsigned PROD_W = 10;
  localparam int unsigned DOT_W = 14;
  localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;
  localparam logic [31:0] QUIET_BIT = 32'h0040_0000;

  typedef enum logic [1:0] {
    FP_MUL,
    FP_ADD,
    FP_CVT
  } fp_op_t;

  typedef struct packed {
    logic        start;
    fp_op_t      op;
    logic [31:0] a;
    logic [31:0] b;
  } fp_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] res;
  } fp_rsp_t;

  typedef struct packed {
    logic        s;
    logic [7:0]  e;
    logic [23:0] m;
    logic        zero;
    logic        inf;
    logic        nan;
  } fp_unp_t;

  function automatic fp_unp_t fp_unpack(input logic [31:0] x);
    fp_unp_t u;
    u.s = x[31];
    u.nan = (&x[30:23]) && (|x[22:0]);
    u.inf = (&x[30:23]) && !(|x[22:0]);
    u.zero = (x[30:0] == 31'd0);
    u.e = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    u.m = {|x[30:23], x[22:0]};
    return u;
  endfunction

  // half to single, exact
  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [4:0] e;
    logic [9:0] m;
    logic [3:0] p;
    logic [9:0] mn;
    logic [7:0] e2;
    logic [31:0] bits;
    e = h[14:10];
    m = h[9:0];
    p = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) p = 4'(i);
    end
    mn = 10'(m << (4'd10 - p));
    e2 = 8'd103 + {4'd0, p};
    if (e == 5'd0) begin
      if (m == 10'd0) bits = {h[15], 31'd0};
      else bits = {h[15], e2, mn, 13'd0};
    end else if (e == 5'd31) begin
      bits = {h[15], 8'hFF, m, 13'd0};
    end else begin
      bits = {h[15], 8'({3'd0, e} + 8'd112), m, 13'd0};
    end
    return bits;
  endfunction

endpackage

// ===== rtl/q2k_lane.sv =====
// one lane: selects the 2-bit weight plane and multiplies by the int8 vector value
module q2k_lane (
  input  logic [7:0]                       wbyte,
  input  logic [1:0]                       plane,
  input  logic [7:0]                       qbyte,
  output logic signed [q2k_pkg::PROD_W-1:0] prod
);
  import q2k_pkg::*;

  logic [1:0] lvl;

  always_comb begin
    case (plane)
      2'd0: lvl = wbyte[1:0];
      2'd1: lvl = wbyte[3:2];
      2'd2: lvl = wbyte[5:4];
      2'd3: lvl = wbyte[7:6];
      default: lvl = wbyte[1:0];
    endcase
  end

  assign prod = $signed({{(PROD_W-2){1'b0}}, lvl})
              * $signed({{(PROD_W-8){qbyte[7]}}, qbyte});

endmodule

// ===== rtl/q2k_merge.sv =====
// registered adder tree that merges the lane products into the sub-block dot
module q2k_merge (
  input  logic                                      clk,
  input  logic [q2k_pkg::LANES*q2k_pkg::PROD_W-1:0] prods,
  output logic signed [q2k_pkg::DOT_W-1:0]          dot_r
);
  import q2k_pkg::*;

  logic signed [DOT_W-1:0] lvl1 [8];
  logic signed [DOT_W-1:0] lvl2 [4];
  logic signed [DOT_W-1:0] lvl3 [2];
  logic signed [DOT_W-1:0] dot_nxt;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      lvl1[i] = DOT_W'($signed(prods[(2*i)*PROD_W +: PROD_W]))
              + DOT_W'($signed(prods[(2*i+1)*PROD_W +: PROD_W]));
    end
    for (int i = 0; i < 4; i++) lvl2[i] = lvl1[2*i] + lvl1[2*i+1];
    for (int i = 0; i < 2; i++) lvl3[i] = lvl2[2*i] + lvl2[2*i+1];
    dot_nxt = lvl3[0] + lvl3[1];
  end

  always_ff @(posedge clk) begin
    dot_r <= dot_nxt;
  end

endmodule

// ===== rtl/q2k_fpu.sv =====
// shared multi-cycle single precision unit: multiply, add and int32 convert
module q2k_fpu (
  input  logic              clk,
  input  logic              rst_n,
  input  q2k_pkg::fp_req_t  req,
  output q2k_pkg::fp_rsp_t  rsp
);
  import q2k_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE,
    F_ALIGN,
    F_NORM,
    F_DENORM,
    F_ROUND,
    F_DONE
  } fstate_t;

  fstate_t            state_r;
  fstate_t            start_nxt;
  logic               s_r;
  logic signed [11:0] e_r;
  logic [63:0]        m_r;
  logic [23:0]        ma_r;
  logic [23:0]        mb_r;
  logic [7:0]         d_r;
  logic               sub_r;
  logic [31:0]        res_r;

  fp_unp_t            ua;
  fp_unp_t            ub;
  logic               a_big;
  logic [47:0]        prod;
  logic [31:0]        mag;
  logic [49:0]        big50;
  logic [49:0]        sm50;
  logic [49:0]        shd;
  logic               lost;
  logic [50:0]        sum51;
  logic [3:0]         lz;
  logic [11:0]        dsh;
  logic [63:0]        dshifted;
  logic               dlost;
  logic               up;
  logic [24:0]        mant25;
  logic [23:0]        mant24;
  logic signed [11:0] ef;

  function automatic logic [3:0] clz8(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd8;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) n = 4'(7 - i);
    end
    return n;
  endfunction

  always_comb begin
    ua = fp_unpack(req.a);
    ub = fp_unpack(req.b);
    a_big = {ua.e, ua.m} >= {ub.e, ub.m};
    prod = ua.m * ub.m;
    mag = req.a[31] ? 32'(-req.a) : req.a;
    big50 = {ma_r, 26'd0};
    sm50 = {mb_r, 26'd0};
    shd = sm50 >> d_r;
    lost = ((shd << d_r) != sm50);
    sum51 = sub_r ? ({1'b0, big50} - {1'b0, shd[49:1], shd[0] | lost})
                  : ({1'b0, big50} + {1'b0, shd[49:1], shd[0] | lost});
    lz = clz8(m_r[63:56]);
    dsh = 12'(12'sd1 - e_r);
    dshifted = m_r >> dsh[5:0];
    dlost = ((dshifted << dsh[5:0]) != m_r);
    up = m_r[39] && ((|m_r[38:0]) || m_r[40]);
    mant25 = {1'b0, m_r[63:40]} + {24'd0, up};
    if (mant25[24]) begin
      mant24 = mant25[24:1];
      ef = e_r + 12'sd1;
    end else begin
      mant24 = mant25[23:0];
      ef = e_r;
    end
    case (req.op)
      FP_MUL: start_nxt = (ua.nan || ub.nan || ua.inf || ub.inf || ua.zero || ub.zero)
                          ? F_DONE : F_NORM;
      FP_ADD: start_nxt = (ua.nan || ub.nan || ua.inf || ub.inf || ua.zero || ub.zero)
                          ? F_DONE : F_ALIGN;
      FP_CVT: start_nxt = (req.a == 32'd0) ? F_DONE : F_NORM;
      default: start_nxt = F_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (req.start) begin
            state_r <= start_nxt;
            case (req.op)
              FP_MUL: begin
                if (ua.nan) res_r <= req.a | QUIET_BIT;
                else if (ub.nan) res_r <= req.b | QUIET_BIT;
                else if ((ua.inf && ub.zero) || (ua.zero && ub.inf)) res_r <= QNAN_DEFAULT;
                else if (ua.inf || ub.inf) res_r <= {ua.s ^ ub.s, 8'hFF, 23'd0};
                else if (ua.zero || ub.zero) res_r <= {ua.s ^ ub.s, 31'd0};
                else begin
                  s_r <= ua.s ^ ub.s;
                  m_r <= {prod, 16'd0};
                  e_r <= $signed({4'd0, ua.e}) + $signed({4'd0, ub.e}) - 12'sd126;
                end
              end
              FP_ADD: begin
                if (ua.nan) res_r <= req.a | QUIET_BIT;
                else if (ub.nan) res_r <= req.b | QUIET_BIT;
                else if (ua.inf && ub.inf && (ua.s != ub.s)) res_r <= QNAN_DEFAULT;
                else if (ua.inf) res_r <= req.a;
                else if (ub.inf) res_r <= req.b;
                else if (ua.zero && ub.zero) res_r <= {ua.s & ub.s, 31'd0};
                else if (ua.zero) res_r <= req.b;
                else if (ub.zero) res_r <= req.a;
                else begin
                  sub_r <= ua.s ^ ub.s;
                  if (a_big) begin
                    s_r <= ua.s;
                    ma_r <= ua.m;
                    mb_r <= ub.m;
                    d_r <= ua.e - ub.e;
                    e_r <= $signed({4'd0, ua.e});
                  end else begin
                    s_r <= ub.s;
                    ma_r <= ub.m;
                    mb_r <= ua.m;
                    d_r <= ub.e - ua.e;
                    e_r <= $signed({4'd0, ub.e});
                  end
                end
              end
              FP_CVT: begin
                if (req.a == 32'd0) res_r <= 32'd0;
                else begin
                  s_r <= req.a[31];
                  m_r <= {mag, 32'd0};
                  e_r <= 12'sd158;
                end
              end
              default: res_r <= QNAN_DEFAULT;
            endcase
          end
        end
        F_ALIGN: begin
          if (sum51 == 51'd0) begin
            res_r <= 32'd0;
            state_r <= F_DONE;
          end else begin
            m_r <= {sum51, 13'd0};
            e_r <= e_r + 12'sd1;
            state_r <= F_NORM;
          end
        end
        F_NORM: begin
          if (m_r[63:56] == 8'd0) begin
            m_r <= m_r << 8;
            e_r <= e_r - 12'sd8;
          end else begin
            m_r <= m_r << lz;
            e_r <= e_r - $signed({8'd0, lz});
            state_r <= F_DENORM;
          end
        end
        F_DENORM: begin
          if (e_r < 12'sd1) begin
            if (dsh >= 12'd64) m_r <= {63'd0, |m_r};
            else m_r <= {dshifted[63:1], dshifted[0] | dlost};
            e_r <= 12'sd1;
          end
          state_r <= F_ROUND;
        end
        F_ROUND: begin
          if (ef >= 12'sd255) res_r <= {s_r, 8'hFF, 23'd0};
          else res_r <= {s_r, mant24[23] ? ef[7:0] : 8'd0, mant24[22:0]};
          state_r <= F_DONE;
        end
        F_DONE: begin
          state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  assign rsp.done = (state_r == F_DONE);
  assign rsp.res = res_r;

endmodule

// ===== rtl/q2k_q8k_row_dot_product.sv =====
// top level: 2-bit by 8-bit quantized row dot product with float fold per super-block
// Takes one 16-element sub-block per cycle while a super-block streams in; 16 lanes
// form the products and a registered adder tree merges them, and integer scaled and
// min sums collect behind a three-stage pipeline. After the sixteenth sub-block of a
// super-block the input stalls while the pipeline drains, then a single shared float
// unit runs eight operations in turn (two scale products, two int-to-float converts,
// two products and two adds into the row accumulator), a fold step clears the sums,
// and an emit step ends each row. A row result waits in an output register; a new
// row result is held back only while the previous one is still untaken.
module q2k_q8k_row_dot_product (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_weight_bytes_low,
  input  logic [63:0] in_weight_bytes_high,
  input  logic [63:0] in_vector_quants_low,
  input  logic [63:0] in_vector_quants_high,
  input  logic [7:0]  in_scale_and_min,
  input  logic signed [15:0] in_vector_block_sum,
  input  logic [15:0] in_weight_scale_half,
  input  logic [15:0] in_weight_min_half,
  input  logic [31:0] in_vector_scale_single,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_row_result,
  output logic [15:0] out_row_number,
  output logic        out_last_row
);
  import q2k_pkg::*;

  typedef enum logic [2:0] {
    S_RUN,
    S_DRAIN,
    S_ISSUE,
    S_WAIT,
    S_FOLD,
    S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    ST_DALL,
    ST_DMN,
    ST_CVT_MIN,
    ST_T1,
    ST_ADD_T1,
    ST_CVT_SDS,
    ST_T2,
    ST_ADD_T2
  } step_t;

  state_t       state_r;
  step_t        step_r;
  logic [8:0]   bpr_r;
  logic [15:0]  rows_r;
  logic [3:0]   sbc_r;
  logic [7:0]   bc_r;
  logic [15:0]  row_r;
  logic [31:0]  sds_r;
  logic [31:0]  ms_r;
  logic [31:0]  acc_r;
  logic [31:0]  xd_r;
  logic [31:0]  ad_r;
  logic [31:0]  amin_r;
  logic [31:0]  dall_r;
  logic [31:0]  dmn_r;
  logic [31:0]  tmp_r;
  logic         out_valid_r;
  logic [31:0]  out_result_r;
  logic [15:0]  out_row_r;
  logic         out_last_r;

  logic [127:0] wb_a_r;
  logic [127:0] qb_a_r;
  logic [1:0]   plane_a_r;
  logic [3:0]   sc_a_r;
  logic [3:0]   mn_a_r;
  logic [15:0]  bsum_a_r;
  logic         va_r;
  logic [3:0]   sc_b_r;
  logic [3:0]   mn_b_r;
  logic [15:0]  bsum_b_r;
  logic         vb_r;

  logic                          accept;
  logic                          cfg_wr;
  logic [LANES*PROD_W-1:0]       prods;
  logic signed [DOT_W-1:0]       dot;
  fp_req_t                       req;
  fp_rsp_t                       rsp;
  logic [8:0]                    bpr_eff;
  logic [15:0]                   rows_eff;
  logic                          more_blocks;
  logic                          last;
  logic [31:0]                   sd_term;
  logic [31:0]                   ms_term;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = paddr[2] ? {16'd0, rows_r} : {23'd0, bpr_r};
  assign in_ready = (state_r == S_RUN);
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpr_r <= 9'd1;
      rows_r <= 16'd1;
    end else if (cfg_wr) begin
      if (paddr[2]) rows_r <= pwdata[15:0];
      else bpr_r <= pwdata[8:0];
    end
  end

  // stage a: capture the request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= accept;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      wb_a_r <= {in_weight_bytes_high, in_weight_bytes_low};
      qb_a_r <= {in_vector_quants_high, in_vector_quants_low};
      plane_a_r <= sbc_r[2:1];
      sc_a_r <= in_scale_and_min[3:0];
      mn_a_r <= in_scale_and_min[7:4];
      bsum_a_r <= in_vector_block_sum;
    end
    sc_b_r <= sc_a_r;
    mn_b_r <= mn_a_r;
    bsum_b_r <= bsum_a_r;
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    q2k_lane u_lane (
      .wbyte (wb_a_r[8*k +: 8]),
      .plane (plane_a_r),
      .qbyte (qb_a_r[8*k +: 8]),
      .prod  (prods[PROD_W*k +: PROD_W])
    );
  end

  q2k_merge u_merge (
    .clk   (clk),
    .prods (prods),
    .dot_r (dot)
  );

  q2k_fpu u_fpu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  always_comb begin
    sd_term = $signed({28'd0, sc_b_r}) * $signed({{(32-DOT_W){dot[DOT_W-1]}}, dot});
    ms_term = $signed({28'd0, mn_b_r}) * $signed({{16{bsum_b_r[15]}}, bsum_b_r});
    bpr_eff = (bpr_r == 9'd0) ? 9'd1 : ((bpr_r > 9'(SUPER_BLOCK)) ? 9'(SUPER_BLOCK) : bpr_r);
    rows_eff = (rows_r == 16'd0) ? 16'd1 : rows_r;
    more_blocks = ({1'b0, bc_r} + 9'd1) < bpr_eff;
    last = ({1'b0, row_r} + 17'd1) >= {1'b0, rows_eff};
    req.start = (state_r == S_ISSUE);
    req.op = FP_MUL;
    req.a = xd_r;
    req.b = ad_r;
    case (step_r)
      ST_DALL: begin
        req.op = FP_MUL;
        req.a = xd_r;
        req.b = ad_r;
      end
      ST_DMN: begin
        req.op = FP_MUL;
        req.a = {~xd_r[31], xd_r[30:0]};
        req.b = amin_r;
      end
      ST_CVT_MIN: begin
        req.op = FP_CVT;
        req.a = ms_r;
        req.b = 32'd0;
      end
      ST_T1: begin
        req.op = FP_MUL;
        req.a = dmn_r;
        req.b = tmp_r;
      end
      ST_ADD_T1, ST_ADD_T2: begin
        req.op = FP_ADD;
        req.a = acc_r;
        req.b = tmp_r;
      end
      ST_CVT_SDS: begin
        req.op = FP_CVT;
        req.a = sds_r;
        req.b = 32'd0;
      end
      ST_T2: begin
        req.op = FP_MUL;
        req.a = dall_r;
        req.b = tmp_r;
      end
      default: begin
        req.op = FP_MUL;
        req.a = xd_r;
        req.b = ad_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RUN;
      step_r <= ST_DALL;
      sbc_r <= 4'd0;
      bc_r <= 8'd0;
      row_r <= 16'd0;
      sds_r <= 32'd0;
      ms_r <= 32'd0;
      acc_r <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_EMIT) out_valid_r <= 1'b0;
      if (vb_r) begin
        sds_r <= sds_r + sd_term;
        ms_r <= ms_r + ms_term;
      end
      case (state_r)
        S_RUN: begin
          if (accept) begin
            sbc_r <= sbc_r + 4'd1;
            if (sbc_r == 4'd15) begin
              xd_r <= in_vector_scale_single;
              ad_r <= half_to_single(in_weight_scale_half);
              amin_r <= half_to_single(in_weight_min_half);
              state_r <= S_DRAIN;
            end
          end
        end
        S_DRAIN: begin
          if (!va_r && !vb_r) begin
            step_r <= ST_DALL;
            state_r <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (rsp.done) begin
            state_r <= (step_r == ST_ADD_T2) ? S_FOLD : S_ISSUE;
            case (step_r)
              ST_DALL: begin
                dall_r <= rsp.res;
                step_r <= ST_DMN;
              end
              ST_DMN: begin
                dmn_r <= rsp.res;
                step_r <= ST_CVT_MIN;
              end
              ST_CVT_MIN: begin
                tmp_r <= rsp.res;
                step_r <= ST_T1;
              end
              ST_T1: begin
                tmp_r <= rsp.res;
                step_r <= ST_ADD_T1;
              end
              ST_ADD_T1: begin
                acc_r <= rsp.res;
                step_r <= ST_CVT_SDS;
              end
              ST_CVT_SDS: begin
                tmp_r <= rsp.res;
                step_r <= ST_T2;
              end
              ST_T2: begin
                tmp_r <= rsp.res;
                step_r <= ST_ADD_T2;
              end
              ST_ADD_T2: begin
                acc_r <= rsp.res;
              end
              default: step_r <= ST_DALL;
            endcase
          end
        end
        S_FOLD: begin
          sds_r <= 32'd0;
          ms_r <= 32'd0;
          if (more_blocks) begin
            bc_r <= bc_r + 8'd1;
            state_r <= S_RUN;
          end else begin
            bc_r <= 8'd0;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_result_r <= acc_r;
            out_row_r <= row_r;
            out_last_r <= last;
            row_r <= last ? 16'd0 : row_r + 16'd1;
            acc_r <= 32'd0;
            state_r <= S_RUN;
          end
        end
        default: state_r <= S_RUN;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_row_result = out_result_r;
  assign out_row_number = out_row_r;
  assign out_last_row = out_last_r;

endmodule

// ===== rtl/q2k_checker.sv =====
// port-level checks for the row dot product, bound to the top level
module q2k_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        pready,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_row_result,
  input logic [15:0] out_row_number,
  input logic        out_last_row
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row_result)
      && $stable(out_row_number) && $stable(out_last_row))
    else $error("result changed while stalled");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_emit_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("row result emitted while taking requests");

  a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("pready low");

endmodule

bind q2k_q8k_row_dot_product q2k_checker u_q2k_checker (.*);
